@@ rtl/core/deficit_round_robin_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// DRR scheduler assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// assertion clocked by clk_i, off while rst_ni is low
`define DRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// assertion clocked by clk_i, checked during reset too
`define DRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DRR_ASSERT(lbl, prop, msg)
`define DRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/drr_pkg.sv @@
// ----------------------------------------------------------------------------
// drr_pkg
// Types, sizes and codes shared by the DRR scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

  // sizes
  localparam int FLOWS     = 1024;
  localparam int NQ        = FLOWS + 1;
  localparam int SLOTS     = 4096;
  localparam int PKT_MAX   = 2048;
  localparam int PKT_MIN   = 64;
  localparam int DROP_CAP  = 32;
  localparam int FLOW_W    = $clog2(NQ);
  localparam int RCNT_W    = $clog2(NQ + 1);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int INIT_N    = (SLOTS > NQ) ? SLOTS : NQ;
  localparam int INIT_W    = $clog2(INIT_N);
  localparam int LEN_W     = 12;
  localparam int TAG_W     = 16;
  localparam int HASH_W    = 32;
  localparam int BYTES_W   = 24;
  localparam int DEF_W     = 18;
  localparam int Q_W       = 16;
  localparam int LIM_W     = 24;
  localparam int DROP_W    = $clog2(DROP_CAP + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;

  // reset values of the registers
  localparam logic [Q_W-1:0]   QUANTUM_RST = Q_W'(600);
  localparam logic [LIM_W-1:0] LIMIT_RST   = LIM_W'(1000 * 1024);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = CFG_IDX_W'(1);

  // request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DROP = 2'd1,
    KIND_DEQ  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    logic              req_type;
    logic [HASH_W-1:0] flow_hash;
    logic              unclassified;
    logic [LEN_W-1:0]  pkt_len;
    logic [TAG_W-1:0]  pkt_tag;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic [FLOW_W-1:0] flow_index;
    logic [LEN_W-1:0]  out_len;
    logic [TAG_W-1:0]  out_tag;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  head;
    logic [SLOT_W-1:0]  tail;
    logic [CNT_W-1:0]   pkts;
    logic [BYTES_W-1:0] bytes;
    logic [DEF_W-1:0]   deficit;
    logic               active;
  } flow_rec_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } slot_dat_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ENQ_CHK,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_SCAN,
    ST_SCAN_SEL,
    ST_TK_RD,
    ST_TK_WR,
    ST_DQ_POP,
    ST_DQ_FRD,
    ST_DQ_EVAL
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_ACCEPT,
    OP_ENQ_RD,
    OP_ENQ_WR,
    OP_SCAN,
    OP_SCAN_SEL,
    OP_TK_RD,
    OP_TK_WR,
    OP_DQ_POP,
    OP_DQ_FRD,
    OP_DQ_EVAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   scan_clr;
    logic   full;
    logic   deq;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic free_empty;
    logic enq_more;
    logic scan_last;
    logic best_zero;
    logic tk_more;
    logic enough;
    logic ring_empty;
    logic pkts_zero;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/drr_ctrl.sv @@
// ----------------------------------------------------------------------------
// drr_ctrl
// Sequencer for enqueue, drop scan, head take and ring rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  wire                  req_type_i,
  input  drr_pkg::dp_status_t  sts_i,
  output drr_pkg::dp_cmd_t     cmd_o,
  output logic                 busy
);
  import drr_pkg::*;

  ctl_state_e state_q, state_d;
  logic       full_q, full_d;
  logic       deq_q, deq_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      full_q  <= 1'b0;
      deq_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      deq_q   <= deq_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    full_d       = full_q;
    deq_d        = deq_q;
    cmd_o.op       = OP_NONE;
    cmd_o.scan_clr = 1'b0;
    cmd_o.full     = full_q;
    cmd_o.deq      = deq_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = OP_ACCEPT;
          full_d   = 1'b0;
          deq_d    = (req_type_i == REQ_DEQ);
          state_d  = (req_type_i == REQ_DEQ) ? ST_DQ_POP : ST_ENQ_CHK;
        end
      end
      ST_ENQ_CHK: begin
        cmd_o.scan_clr = 1'b1;
        if (sts_i.free_empty) begin
          full_d  = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_ENQ_RD;
        end
      end
      ST_ENQ_RD: begin
        cmd_o.op = OP_ENQ_RD;
        state_d  = ST_ENQ_WR;
      end
      ST_ENQ_WR: begin
        cmd_o.op       = OP_ENQ_WR;
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.enq_more ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.scan_last) state_d = ST_SCAN_SEL;
      end
      ST_SCAN_SEL: begin
        cmd_o.op = OP_SCAN_SEL;
        if (!sts_i.best_zero) begin
          state_d = ST_TK_RD;
        end else if (full_q) begin
          full_d  = 1'b0;
          state_d = ST_ENQ_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TK_RD: begin
        cmd_o.op = OP_TK_RD;
        state_d  = ST_TK_WR;
      end
      ST_TK_WR: begin
        cmd_o.op       = OP_TK_WR;
        cmd_o.scan_clr = 1'b1;
        if (deq_q) begin
          state_d = sts_i.enough ? ST_IDLE : ST_DQ_POP;
        end else if (full_q) begin
          full_d  = 1'b0;
          state_d = ST_ENQ_RD;
        end else begin
          state_d = sts_i.tk_more ? ST_SCAN : ST_IDLE;
        end
      end
      ST_DQ_POP: begin
        cmd_o.op = OP_DQ_POP;
        state_d  = sts_i.ring_empty ? ST_IDLE : ST_DQ_FRD;
      end
      ST_DQ_FRD: begin
        cmd_o.op = OP_DQ_FRD;
        state_d  = ST_DQ_EVAL;
      end
      ST_DQ_EVAL: begin
        cmd_o.op = OP_DQ_EVAL;
        state_d  = sts_i.pkts_zero ? ST_DQ_POP : ST_TK_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/drr_dpath.sv @@
// ----------------------------------------------------------------------------
// drr_dpath
// Slot store, flow table, service ring, scan unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deficit_round_robin_scheduler_macros.svh"

module drr_dpath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  drr_pkg::dp_cmd_t             cmd_i,
  input  drr_pkg::req_t                req_i,
  input  wire                          cfg_we_i,
  input  wire [drr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [drr_pkg::CFG_W-1:0]     cfg_data_i,
  output drr_pkg::dp_status_t          sts_o,
  output drr_pkg::res_t                res_o,
  output logic                         res_valid_o
);
  import drr_pkg::*;

  // memories
  flow_rec_t         flow_mem [NQ];
  slot_dat_t         sdat_mem [SLOTS];
  logic [SLOT_W-1:0] snxt_mem [SLOTS];
  logic [FLOW_W-1:0] ring_mem [NQ];

  flow_rec_t         flow_rd_q, flow_wdata;
  logic [FLOW_W-1:0] flow_raddr, flow_waddr;
  logic              flow_we;
  slot_dat_t         sdat_rd_q, sdat_wdata;
  logic [SLOT_W-1:0] snxt_rd_q, snxt_wdata, slot_raddr, sdat_waddr, snxt_waddr;
  logic              sdat_we, snxt_we;
  logic [FLOW_W-1:0] ring_rd_q, ring_wdata, ring_waddr;
  logic              ring_we;

  // registers
  logic [Q_W-1:0]     quantum_q;
  logic [LIM_W-1:0]   limit_q;
  logic [FLOW_W-1:0]  ef_q, ef_d, cur_q, cur_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [DROP_W-1:0]  drops_q, drops_d;
  logic [SLOT_W-1:0]  free_head_q, free_head_d;
  logic [CNT_W-1:0]   free_count_q, free_count_d;
  logic [FLOW_W-1:0]  ring_head_q, ring_head_d;
  logic [RCNT_W-1:0]  ring_count_q, ring_count_d;
  logic [BYTES_W-1:0] total_q, total_d;
  logic [RCNT_W-1:0]  scan_q, scan_d;
  logic [BYTES_W-1:0] best_bytes_q, best_bytes_d;
  logic [FLOW_W-1:0]  best_idx_q, best_idx_d;
  flow_rec_t          best_rec_q, best_rec_d, fr_q, fr_d;
  logic [INIT_W-1:0]  init_q, init_d;
  res_t               res_q, res_d;
  logic               res_valid_d, res_valid_q;

  // helpers
  logic [Q_W-1:0]     q_eff;
  logic [DEF_W:0]     def_sum;
  logic [DEF_W-1:0]   d_sat;
  logic               enough;
  logic [RCNT_W:0]    ring_sum;
  logic [FLOW_W-1:0]  ring_tail;
  logic [BYTES_W-1:0] total_enq, total_tk;
  logic               enq_more, tk_more, fill;
  logic [LEN_W-1:0]   len_c;
  logic [CNT_W-1:0]   pkts_tk;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_QUANTUM) quantum_q <= cfg_data_i[Q_W-1:0];
      else if (cfg_idx_i == CFG_LIMIT) limit_q <= cfg_data_i[LIM_W-1:0];
    end
  end

  // deficit update with saturation, zero quantum acts as one
  assign q_eff   = (quantum_q == '0) ? Q_W'(1) : quantum_q;
  assign def_sum = {1'b0, fr_q.deficit} + (DEF_W+1)'(q_eff);
  assign d_sat   = def_sum[DEF_W] ? '1 : def_sum[DEF_W-1:0];
  assign enough  = d_sat >= DEF_W'(sdat_rd_q.len);

  // ring tail position
  assign ring_sum  = (RCNT_W+1)'(ring_head_q) + (RCNT_W+1)'(ring_count_q);
  assign ring_tail = (ring_sum >= (RCNT_W+1)'(NQ)) ? FLOW_W'(ring_sum - (RCNT_W+1)'(NQ))
                                                  : FLOW_W'(ring_sum);

  // limit checks after an enqueue and after a drop
  assign fill      = (free_count_q != '0);
  assign total_enq = total_q + (fill ? BYTES_W'(len_q) : '0);
  assign enq_more  = (total_enq > limit_q) && (drops_q < DROP_W'(DROP_CAP));
  assign total_tk  = total_q - BYTES_W'(sdat_rd_q.len);
  assign tk_more   = (total_tk > limit_q)
                   && (({1'b0, drops_q} + 1'b1) < (DROP_W+1)'(DROP_CAP));
  assign pkts_tk   = fr_q.pkts - 1'b1;

  // packet length clamp
  always_comb begin
    if (req_i.pkt_len < LEN_W'(PKT_MIN))      len_c = LEN_W'(PKT_MIN);
    else if (req_i.pkt_len > LEN_W'(PKT_MAX)) len_c = LEN_W'(PKT_MAX);
    else                                      len_c = req_i.pkt_len;
  end

  // operation decode
  always_comb begin
    ef_d         = ef_q;
    cur_d        = cur_q;
    len_d        = len_q;
    tag_d        = tag_q;
    drops_d      = drops_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    ring_head_d  = ring_head_q;
    ring_count_d = ring_count_q;
    total_d      = total_q;
    scan_d       = scan_q;
    best_bytes_d = best_bytes_q;
    best_idx_d   = best_idx_q;
    best_rec_d   = best_rec_q;
    fr_d         = fr_q;
    init_d       = init_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    flow_raddr   = '0;
    flow_we      = 1'b0;
    flow_waddr   = cur_q;
    flow_wdata   = fr_q;
    slot_raddr   = fr_q.head;
    sdat_we      = 1'b0;
    sdat_waddr   = free_head_q;
    sdat_wdata   = '{len: len_q, tag: tag_q};
    snxt_we      = 1'b0;
    snxt_waddr   = fr_q.head;
    snxt_wdata   = free_head_q;
    ring_we      = 1'b0;
    ring_waddr   = ring_tail;
    ring_wdata   = cur_q;

    case (cmd_i.op)
      // clearing pass: free list chain and zeroed flow table
      OP_INIT: begin
        init_d = init_q + 1'b1;
        if ({1'b0, init_q} < (INIT_W+1)'(SLOTS)) begin
          snxt_we    = 1'b1;
          snxt_waddr = init_q[SLOT_W-1:0];
          snxt_wdata = SLOT_W'(init_q + 1'b1);
        end
        if ({1'b0, init_q} < (INIT_W+1)'(NQ)) begin
          flow_we    = 1'b1;
          flow_waddr = init_q[FLOW_W-1:0];
          flow_wdata = '0;
        end
      end
      // latch the request
      OP_ACCEPT: begin
        ef_d    = req_i.unclassified ? FLOW_W'(FLOWS) : FLOW_W'(req_i.flow_hash % FLOWS);
        len_d   = len_c;
        tag_d   = req_i.pkt_tag;
        drops_d = '0;
      end
      OP_ENQ_RD: begin
        flow_raddr = ef_q;
        slot_raddr = free_head_q;
      end
      // append to the flow, activate it if idle
      OP_ENQ_WR: begin
        if (fill) begin
          sdat_we      = 1'b1;
          sdat_waddr   = free_head_q;
          snxt_we      = (flow_rd_q.pkts != '0);
          snxt_waddr   = flow_rd_q.tail;
          snxt_wdata   = free_head_q;
          free_head_d  = snxt_rd_q;
          free_count_d = free_count_q - 1'b1;
          flow_we      = 1'b1;
          flow_waddr   = ef_q;
          flow_wdata   = flow_rd_q;
          if (flow_rd_q.pkts == '0) flow_wdata.head = free_head_q;
          flow_wdata.tail   = free_head_q;
          flow_wdata.pkts   = flow_rd_q.pkts + 1'b1;
          flow_wdata.bytes  = flow_rd_q.bytes + BYTES_W'(len_q);
          flow_wdata.active = 1'b1;
          total_d           = total_enq;
          if (!flow_rd_q.active) begin
            ring_we      = 1'b1;
            ring_wdata   = ef_q;
            ring_count_d = ring_count_q + 1'b1;
          end
        end
        res_valid_d = 1'b1;
        res_d       = '{kind: KIND_ENQ, flow_index: ef_q, out_len: '0, out_tag: '0,
                        last: !enq_more};
      end
      // fattest flow search, one flow per cycle, read data in the next cycle
      OP_SCAN: begin
        flow_raddr = (scan_q < RCNT_W'(NQ)) ? scan_q[FLOW_W-1:0] : '0;
        if (scan_q != '0 && flow_rd_q.bytes > best_bytes_q) begin
          best_bytes_d = flow_rd_q.bytes;
          best_idx_d   = FLOW_W'(scan_q - 1'b1);
          best_rec_d   = flow_rd_q;
        end
        if (scan_q != RCNT_W'(NQ)) scan_d = scan_q + 1'b1;
      end
      OP_SCAN_SEL: begin
        fr_d  = best_rec_q;
        cur_d = best_idx_q;
      end
      OP_TK_RD: begin
        slot_raddr = fr_q.head;
      end
      // take the head packet, or pass the flow on with more credit
      OP_TK_WR: begin
        flow_we    = 1'b1;
        flow_waddr = cur_q;
        flow_wdata = fr_q;
        if (!cmd_i.deq || enough) begin
          snxt_we      = 1'b1;
          snxt_waddr   = fr_q.head;
          snxt_wdata   = free_head_q;
          free_head_d  = fr_q.head;
          free_count_d = free_count_q + 1'b1;
          total_d      = total_tk;
          flow_wdata.head  = snxt_rd_q;
          flow_wdata.pkts  = pkts_tk;
          flow_wdata.bytes = fr_q.bytes - BYTES_W'(sdat_rd_q.len);
          res_valid_d = 1'b1;
          res_d.flow_index = cur_q;
          res_d.out_len    = sdat_rd_q.len;
          res_d.out_tag    = sdat_rd_q.tag;
          if (cmd_i.deq) begin
            res_d.kind = KIND_DEQ;
            res_d.last = 1'b1;
            if (pkts_tk == '0) begin
              flow_wdata.deficit = '0;
              flow_wdata.active  = 1'b0;
            end else begin
              flow_wdata.deficit = d_sat - DEF_W'(sdat_rd_q.len);
              ring_we      = 1'b1;
              ring_count_d = ring_count_q + 1'b1;
            end
          end else begin
            res_d.kind = KIND_DROP;
            res_d.last = !cmd_i.full && !tk_more;
            drops_d    = drops_q + 1'b1;
          end
        end else begin
          flow_wdata.deficit = d_sat;
          ring_we      = 1'b1;
          ring_count_d = ring_count_q + 1'b1;
        end
      end
      // pop the ring front, or report an empty scheduler
      OP_DQ_POP: begin
        if (ring_count_q != '0) begin
          ring_head_d  = (ring_head_q == FLOW_W'(NQ - 1)) ? '0 : ring_head_q + 1'b1;
          ring_count_d = ring_count_q - 1'b1;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_NONE, flow_index: '0, out_len: '0, out_tag: '0,
                          last: 1'b1};
        end
      end
      OP_DQ_FRD: begin
        flow_raddr = ring_rd_q;
        cur_d      = ring_rd_q;
      end
      // retire a flow emptied by drops
      OP_DQ_EVAL: begin
        fr_d = flow_rd_q;
        if (flow_rd_q.pkts == '0) begin
          flow_we            = 1'b1;
          flow_waddr         = cur_q;
          flow_wdata         = flow_rd_q;
          flow_wdata.active  = 1'b0;
          flow_wdata.deficit = '0;
        end
      end
      default: ;
    endcase

    if (cmd_i.scan_clr) begin
      scan_d       = '0;
      best_bytes_d = '0;
      best_idx_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drops_q      <= '0;
      free_head_q  <= '0;
      free_count_q <= CNT_W'(SLOTS);
      ring_head_q  <= '0;
      ring_count_q <= '0;
      total_q      <= '0;
      scan_q       <= '0;
      init_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      drops_q      <= drops_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      ring_head_q  <= ring_head_d;
      ring_count_q <= ring_count_d;
      total_q      <= total_d;
      scan_q       <= scan_d;
      init_q       <= init_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ef_q         <= ef_d;
    cur_q        <= cur_d;
    len_q        <= len_d;
    tag_q        <= tag_d;
    best_bytes_q <= best_bytes_d;
    best_idx_q   <= best_idx_d;
    best_rec_q   <= best_rec_d;
    fr_q         <= fr_d;
    res_q        <= res_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (flow_we) flow_mem[flow_waddr] <= flow_wdata;
    flow_rd_q <= flow_mem[flow_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sdat_we) sdat_mem[sdat_waddr] <= sdat_wdata;
    sdat_rd_q <= sdat_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (snxt_we) snxt_mem[snxt_waddr] <= snxt_wdata;
    snxt_rd_q <= snxt_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_rd_q <= ring_mem[ring_head_q];
  end

  // status to the controller
  assign sts_o.init_last  = (init_q == INIT_W'(INIT_N - 1));
  assign sts_o.free_empty = !fill;
  assign sts_o.enq_more   = enq_more;
  assign sts_o.scan_last  = (scan_q == RCNT_W'(NQ));
  assign sts_o.best_zero  = (best_bytes_q == '0);
  assign sts_o.tk_more    = tk_more;
  assign sts_o.enough     = enough;
  assign sts_o.ring_empty = (ring_count_q == '0);
  assign sts_o.pkts_zero  = (flow_rd_q.pkts == '0);

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // checks
  `DRR_ASSERT(a_free_bound, free_count_q <= CNT_W'(SLOTS), "free slot count above store size")
  `DRR_ASSERT(a_ring_bound, (ring_count_q <= RCNT_W'(NQ)) && (ring_head_q < FLOW_W'(NQ)), "ring state out of range")
  `DRR_ASSERT(a_res_src, res_valid_q |-> ($past(cmd_i.op) == OP_ENQ_WR || $past(cmd_i.op) == OP_TK_WR || $past(cmd_i.op) == OP_DQ_POP), "result strobe without a producing step")
  `DRR_ASSERT(a_drop_cap, (cmd_i.op == OP_TK_WR && !cmd_i.deq) |-> (drops_q < DROP_W'(DROP_CAP)), "too many drops for one enqueue")
  `DRR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !res_valid_q, "result strobe right after reset")

endmodule

`default_nettype wire

@@ rtl/core/deficit_round_robin_scheduler.sv @@
// Enqueue: check, read and write steps, then the enqueue-done strobe; a drop adds
//   a one-flow-per-cycle scan of the flow table, a select, a head read and a write.
// Dequeue: a ring visit runs pop, flow read, evaluate, head read and head write; a
//   flow short of credit costs a full visit, one emptied by drops the first three.
// busy falls with the last one-cycle strobe, so the next transfer starts then.
// After reset a clearing pass builds the free list; busy stays high through it.
// ----------------------------------------------------------------------------
// deficit_round_robin_scheduler
// Deficit round robin scheduler with per-flow linked queues in a shared store.
// ----------------------------------------------------------------------------
`default_nettype none

module deficit_round_robin_scheduler (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  drr_pkg::req_t                req_i,
  output logic                         res_valid_o,
  output drr_pkg::res_t                res_o,
  input  wire                          cfg_we_i,
  input  wire [drr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [drr_pkg::CFG_W-1:0]     cfg_data_i
);
  import drr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  drr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  // storage and arithmetic
  drr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

`default_nettype wire

@@ dv/drr_sched_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_sched_checker
// Watches the request, result and register ports of the scheduler, keeps its
// own model of the flow queues and the service ring, and compares every result
// strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_sched_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire                          busy_i,
  input  drr_pkg::req_t                req_i,
  input  wire                          res_valid_i,
  input  drr_pkg::res_t                res_i,
  input  wire                          cfg_we_i,
  input  wire [drr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [drr_pkg::CFG_W-1:0]     cfg_data_i,
  output int                           fail_cnt_o,
  output int                           pending_o
);
  import drr_pkg::*;

  localparam int DEF_SAT   = (1 << DEF_W) - 1;
  localparam int EXP_DEPTH = 64;
  localparam int BURST_MAX = DROP_CAP + 1;

  // model of the slot store and flow table
  logic [LEN_W-1:0] slot_len_m [SLOTS];
  logic [TAG_W-1:0] slot_tag_m [SLOTS];
  int               slot_link  [SLOTS];
  int               free_top, free_num;
  int               fq_head [NQ];
  int               fq_tail [NQ];
  int               fq_pkts [NQ];
  int               fq_bytes[NQ];
  int               fq_def  [NQ];
  bit               fq_on   [NQ];
  int               svc_ring[NQ];
  int               svc_front, svc_num;
  int               queued_bytes;
  int               quantum_m, limit_m;

  // expected results in arrival order, and the results of one request
  res_t             exp_buf [EXP_DEPTH];
  int               exp_rd, exp_wr;
  res_t             burst_buf [BURST_MAX];
  int               burst_n;
  int               mism_cnt;

  assign pending_o = exp_wr - exp_rd;

  function automatic void model_reset();
    for (int i = 0; i < SLOTS; i++) slot_link[i] = (i + 1) % SLOTS;
    for (int i = 0; i < NQ; i++) begin
      fq_pkts[i] = 0; fq_bytes[i] = 0; fq_def[i] = 0; fq_on[i] = 0;
    end
    free_top = 0; free_num = SLOTS;
    svc_front = 0; svc_num = 0; queued_bytes = 0;
    quantum_m = int'(QUANTUM_RST);
    limit_m = int'(LIMIT_RST);
  endfunction

  function automatic void add_result(kind_e k, int f, int len, int tag);
    res_t r;
    r.kind       = k;
    r.flow_index = FLOW_W'(f);
    r.out_len    = LEN_W'(len);
    r.out_tag    = TAG_W'(tag);
    r.last       = 1'b0;
    burst_buf[burst_n] = r;
    burst_n++;
  endfunction

  function automatic void ring_add(int f);
    svc_ring[(svc_front + svc_num) % NQ] = f;
    svc_num++;
  endfunction

  function automatic int ring_take();
    int f;
    f = svc_ring[svc_front];
    svc_front = (svc_front + 1) % NQ;
    svc_num--;
    return f;
  endfunction

  // unlink the head packet of flow f and return its slot to the free list
  function automatic void pop_head(int f, output int len, output int tag);
    int s;
    s = fq_head[f];
    len = slot_len_m[s];
    tag = slot_tag_m[s];
    fq_head[f] = slot_link[s];
    fq_pkts[f]--;
    fq_bytes[f] -= len;
    queued_bytes -= len;
    slot_link[s] = free_top;
    free_top = s;
    free_num++;
  endfunction

  // drop the head of the flow with most bytes, lowest index on a tie
  function automatic bit drop_fattest();
    int best, idx, len, tag;
    best = 0; idx = 0;
    for (int i = 0; i < NQ; i++) begin
      if (fq_bytes[i] > best) begin
        best = fq_bytes[i];
        idx = i;
      end
    end
    if (best == 0 || fq_pkts[idx] == 0) return 0;
    pop_head(idx, len, tag);
    add_result(KIND_DROP, idx, len, tag);
    return 1;
  endfunction

  function automatic void predict(req_t rq);
    int f, len, s, drops, q, d, tag;
    bit sent;
    burst_n = 0;
    drops = 0;
    if (rq.req_type == REQ_ENQ) begin
      f = rq.unclassified ? FLOWS : int'(rq.flow_hash % FLOWS);
      len = rq.pkt_len;
      if (len < PKT_MIN) len = PKT_MIN;
      if (len > PKT_MAX) len = PKT_MAX;
      if (free_num == 0) begin
        void'(drop_fattest());
        drops++;
      end
      if (free_num != 0) begin
        s = free_top;
        free_top = slot_link[s];
        free_num--;
        slot_len_m[s] = LEN_W'(len);
        slot_tag_m[s] = rq.pkt_tag;
        if (fq_pkts[f] == 0) fq_head[f] = s;
        else slot_link[fq_tail[f]] = s;
        fq_tail[f] = s;
        fq_pkts[f]++;
        fq_bytes[f] += len;
        queued_bytes += len;
        if (!fq_on[f]) begin
          fq_on[f] = 1;
          ring_add(f);
        end
      end
      add_result(KIND_ENQ, f, 0, 0);
      while (queued_bytes > limit_m && drops < DROP_CAP) begin
        if (!drop_fattest()) break;
        drops++;
      end
    end else begin
      q = (quantum_m == 0) ? 1 : quantum_m;
      sent = 0;
      while (svc_num != 0 && !sent) begin
        f = ring_take();
        if (fq_pkts[f] == 0) begin
          // flow emptied by drops leaves the ring without credit
          fq_on[f] = 0;
          fq_def[f] = 0;
          continue;
        end
        d = fq_def[f] + q;
        if (d > DEF_SAT) d = DEF_SAT;
        if (d >= slot_len_m[fq_head[f]]) begin
          pop_head(f, len, tag);
          d -= len;
          if (fq_pkts[f] == 0) begin
            d = 0;
            fq_on[f] = 0;
          end else begin
            ring_add(f);
          end
          fq_def[f] = d;
          add_result(KIND_DEQ, f, len, tag);
          sent = 1;
        end else begin
          fq_def[f] = d;
          ring_add(f);
        end
      end
      if (!sent) add_result(KIND_NONE, 0, 0, 0);
    end
    burst_buf[burst_n - 1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) begin
      exp_buf[exp_wr % EXP_DEPTH] = burst_buf[i];
      exp_wr++;
    end
  endfunction

  // result compare, register tracking and prediction on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      model_reset();
      exp_rd = 0;
      exp_wr = 0;
      burst_n = 0;
      fail_cnt_o <= 0;
      mism_cnt = 0;
    end else begin
      if (res_valid_i) begin
        if (exp_wr == exp_rd) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (mism_cnt < 10)
            $display("unexpected result: kind %0d flow %0d len %0d tag %h last %b",
                     res_i.kind, res_i.flow_index, res_i.out_len, res_i.out_tag,
                     res_i.last);
          mism_cnt++;
        end else begin
          e = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (res_i.kind !== e.kind || res_i.flow_index !== e.flow_index ||
              res_i.out_len !== e.out_len || res_i.out_tag !== e.out_tag ||
              res_i.last !== e.last) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (mism_cnt < 10)
              $display("mismatch: exp kind %0d flow %0d len %0d tag %h last %b,",
                       e.kind, e.flow_index, e.out_len, e.out_tag, e.last,
                       " got kind %0d flow %0d len %0d tag %h last %b",
                       res_i.kind, res_i.flow_index, res_i.out_len, res_i.out_tag,
                       res_i.last);
            mism_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_QUANTUM) quantum_m = int'(cfg_data_i[Q_W-1:0]);
        else if (cfg_idx_i == CFG_LIMIT) limit_m = int'(cfg_data_i[LIM_W-1:0]);
      end
      if (start_i && !busy_i) predict(req_i);
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random enqueue and dequeue transfers into the DRR
// scheduler across several register settings, including a deep backlog with
// the largest quantum and a capped drop burst; the checker compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import drr_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req_i = '0;
  logic                 res_valid_o;
  res_t                 res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_QUANTUM;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  int                   fail_cnt, pending;
  bit                   gaps_on;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  deficit_round_robin_scheduler u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  drr_sched_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i,
    .res_valid_i(res_valid_o), .res_i(res_o), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic req_t enq_req(logic [HASH_W-1:0] h, logic u, logic [LEN_W-1:0] l,
                                   logic [TAG_W-1:0] t);
    req_t r;
    r.req_type = REQ_ENQ; r.flow_hash = h; r.unclassified = u;
    r.pkt_len = l; r.pkt_tag = t;
    return r;
  endfunction

  // dequeue with junk in the unused fields
  function automatic req_t deq_req();
    req_t r;
    r = enq_req($urandom(), 1'($urandom()), LEN_W'($urandom()), TAG_W'($urandom()));
    r.req_type = REQ_DEQ;
    return r;
  endfunction

  // hold start until the block takes the transfer, then maybe pause
  task automatic send(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // wait until every result is in and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int lim_hi_hash);
    logic [HASH_W-1:0] h;
    logic [LEN_W-1:0]  l;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        h = ($urandom_range(0, 3) == 0) ? HASH_W'($urandom())
                                        : HASH_W'($urandom_range(0, lim_hi_hash));
        l = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom())
                                        : LEN_W'($urandom_range(PKT_MIN, PKT_MAX));
        send(enq_req(h, $urandom_range(0, 9) == 0, l, TAG_W'($urandom())));
      end else begin
        send(deq_req());
      end
    end
  endtask

  initial begin
    #(1_000_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, field extremes, length clamping
    send(deq_req());
    send(enq_req('0, 1'b0, LEN_W'(0), '0));
    send(enq_req('1, 1'b0, LEN_W'(63), '1));
    send(enq_req(HASH_W'(FLOWS), 1'b0, LEN_W'(PKT_MIN), TAG_W'(16'h5a5a)));
    send(enq_req('1, 1'b1, LEN_W'(PKT_MAX), TAG_W'(16'ha5a5)));
    send(enq_req(HASH_W'(5), 1'b1, LEN_W'(PKT_MAX + 1), TAG_W'(1)));
    send(enq_req(HASH_W'(7), 1'b0, '1, TAG_W'(2)));
    repeat (7) send(deq_req());

    // zero quantum acts as one; small limit empties flows by drops
    settle();
    write_reg(CFG_QUANTUM, '0);
    write_reg(CFG_LIMIT, CFG_W'(PKT_MIN));
    send(enq_req(HASH_W'(3), 1'b0, LEN_W'(PKT_MIN), TAG_W'(3)));
    send(enq_req(HASH_W'(4), 1'b0, LEN_W'(200), TAG_W'(4)));
    send(enq_req(HASH_W'(4), 1'b0, LEN_W'(300), TAG_W'(5)));
    send(enq_req(HASH_W'(9), 1'b0, LEN_W'(PKT_MIN), TAG_W'(6)));
    repeat (3) send(deq_req());

    // random with several settings
    settle();
    write_reg(CFG_QUANTUM, CFG_W'(1));
    write_reg(CFG_LIMIT, CFG_W'($urandom_range(3000, 20000)));
    random_phase(10, 15);
    settle();
    write_reg(CFG_QUANTUM, CFG_W'(QUANTUM_RST));
    write_reg(CFG_LIMIT, CFG_W'(LIMIT_RST));
    random_phase(10, 7);
    settle();
    write_reg(CFG_QUANTUM, CFG_W'($urandom_range(1, 65535)));
    write_reg(CFG_LIMIT, CFG_W'($urandom_range(64, 12000)));
    random_phase(10, 31);

    // deep backlog in two flows, quantum at its largest value
    settle();
    write_reg(CFG_QUANTUM, CFG_W'(16'hffff));
    write_reg(CFG_LIMIT, CFG_W'(24'hffffff));
    gaps_on = 1'b0;
    for (int i = 0; i < 44; i++)
      send(enq_req(HASH_W'($urandom_range(0, 1)), 1'b0,
                   LEN_W'($urandom_range(PKT_MIN, PKT_MAX)), TAG_W'($urandom())));
    repeat (8) send(deq_req());

    // drop burst that stops at the cap, then the rest of the excess
    settle();
    write_reg(CFG_LIMIT, CFG_W'(PKT_MIN));
    send(enq_req(HASH_W'(2), 1'b0, LEN_W'(PKT_MAX), TAG_W'(7)));
    send(enq_req(HASH_W'(1), 1'b1, LEN_W'(PKT_MIN), TAG_W'(8)));

    // closing stretch without pauses
    settle();
    write_reg(CFG_QUANTUM, CFG_W'(QUANTUM_RST));
    write_reg(CFG_LIMIT, CFG_W'(8000));
    random_phase(10, 15);

    start <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0);
    repeat (2000) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ deficit_round_robin_scheduler.f @@
+incdir+rtl/core
rtl/core/drr_pkg.sv
rtl/core/drr_ctrl.sv
rtl/core/drr_dpath.sv
rtl/core/deficit_round_robin_scheduler.sv
dv/drr_sched_checker.sv
dv/testbench.sv
